// ----- src/sidalloc_pkg.sv -----
`default_nettype none
package sidalloc_pkg;

   localparam int MAX_SLOTS = 1024;
   localparam int MIN_SLOTS = 64;
   localparam int SLOT_W    = $clog2(MAX_SLOTS);
   localparam int LIMIT_W   = SLOT_W + 1;
   localparam int GEN_W     = 16;
   localparam int WORD_BITS = 64;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int BM_WORDS  = MAX_SLOTS / WORD_BITS;
   localparam int WORD_AW   = $clog2(BM_WORDS);

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(MAX_SLOTS);

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE = 2'd1;
   localparam logic [1:0] STATUS_IGNORED = 2'd2;

   typedef struct packed {
      logic              func;
      logic [SLOT_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] granted_index;
      logic [GEN_W-1:0]  granted_generation;
   } rsp_type;

   typedef struct packed {
      logic                 bm_we;
      logic [WORD_AW-1:0]   bm_addr;
      logic [WORD_BITS-1:0] bm_wdata;
      logic                 gen_we;
      logic [SLOT_W-1:0]    gen_addr;
      logic [GEN_W-1:0]     gen_wdata;
   } mem_ctrl_type;

   typedef struct packed {
      logic             wrapped;
      logic             first_word;
      logic             last_word;
      logic             word_zero;
      logic [BIT_W-1:0] first_bit;
      logic [BIT_W-1:0] last_bit;
   } scan_ctrl_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] bit_idx;
   } scan_res_type;

endpackage
`default_nettype wire

// ----- src/slot_id_allocator_with_generation_top.sv -----
`default_nettype none
// Slot identifier allocator with a 16-bit generation per slot. An allocate request
// searches next-fit from the hint for a free slot (slot 0 is never handed out) and
// returns its index and generation; a free request clears the slot and bumps its
// generation. The used-slot bitmap is held as 64-bit words and examined one word at a
// time (registered memory read, then a find-first-free over the word). After reset a
// clearing pass zeroes the generations and the bitmap (slot 0 marked as used), with
// requests stalled meanwhile. The slot limit register may be written at any time the
// block holds no request.
module slot_id_allocator_with_generation_top (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire sidalloc_pkg::req_type            req_data,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output sidalloc_pkg::rsp_type                 rsp_data,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire [sidalloc_pkg::LIMIT_W-1:0]       csr_data
);
   import sidalloc_pkg::*;

   mem_ctrl_type         mem;
   scan_ctrl_type        scan_ctl;
   scan_res_type         scan_res;
   logic [WORD_BITS-1:0] bm_rd_data;
   logic [GEN_W-1:0]     gen_rd_data;

   sidalloc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .mem         (mem),
      .bm_rd_data  (bm_rd_data),
      .gen_rd_data (gen_rd_data),
      .scan_ctl    (scan_ctl),
      .scan_res    (scan_res)
   );

   sidalloc_mem u_mem (
      .clock       (clock),
      .mem         (mem),
      .bm_rd_data  (bm_rd_data),
      .gen_rd_data (gen_rd_data)
   );

   sidalloc_scan u_scan (
      .ctl  (scan_ctl),
      .word (bm_rd_data),
      .res  (scan_res)
   );

   // one request at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // a failed or free request never carries a grant
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_DONE |->
         rsp_data.granted_index == '0 && rsp_data.granted_generation == '0)
      else $error("grant on failed request");

   // slot 0 is reserved and never granted
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.granted_generation != '0 |-> rsp_data.granted_index != '0)
      else $error("slot 0 granted");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status == STATUS_DONE || rsp_data.status == STATUS_NO_FREE
                    || rsp_data.status == STATUS_IGNORED)
      else $error("undefined status");

endmodule
`default_nettype wire

// ----- src/sidalloc_mem.sv -----
`default_nettype none
module sidalloc_mem (
   input  wire                                   clock,
   input  wire sidalloc_pkg::mem_ctrl_type       mem,
   output logic [sidalloc_pkg::WORD_BITS-1:0]    bm_rd_data,
   output logic [sidalloc_pkg::GEN_W-1:0]        gen_rd_data
);
   import sidalloc_pkg::*;

   logic [WORD_BITS-1:0] bitmap_ff [BM_WORDS];
   logic [GEN_W-1:0]     gen_ff [MAX_SLOTS];
   logic [WORD_BITS-1:0] bm_rd_ff;
   logic [GEN_W-1:0]     gen_rd_ff;

   always_ff @(posedge clock) begin
      if (mem.bm_we) begin
         bitmap_ff[mem.bm_addr] <= mem.bm_wdata;
      end
      bm_rd_ff <= bitmap_ff[mem.bm_addr];
   end

   always_ff @(posedge clock) begin
      if (mem.gen_we) begin
         gen_ff[mem.gen_addr] <= mem.gen_wdata;
      end
      gen_rd_ff <= gen_ff[mem.gen_addr];
   end

   assign bm_rd_data  = bm_rd_ff;
   assign gen_rd_data = gen_rd_ff;

endmodule
`default_nettype wire

// ----- src/sidalloc_scan.sv -----
`default_nettype none
module sidalloc_scan (
   input  wire sidalloc_pkg::scan_ctrl_type       ctl,
   input  wire [sidalloc_pkg::WORD_BITS-1:0]      word,
   output sidalloc_pkg::scan_res_type             res
);
   import sidalloc_pkg::*;

   localparam logic [WORD_BITS-1:0] ALL = '1;

   logic [WORD_BITS-1:0] ge_first;
   logic [WORD_BITS-1:0] le_last;
   logic [WORD_BITS-1:0] mask;
   logic [WORD_BITS-1:0] free_bits;
   logic [WORD_BITS-1:0] lowest;
   logic [BIT_W-1:0]     idx;

   assign ge_first = ALL << ctl.first_bit;
   assign le_last  = ~((ALL << ctl.last_bit) << 1);

   always_comb begin
      if (!ctl.wrapped) begin
         // hint up to the limit
         mask = (ctl.first_word ? ge_first : ALL) & (ctl.last_word ? le_last : ALL);
      end else begin
         // slot 1 up to just below the hint
         mask = (ctl.word_zero ? (ALL << 1) : ALL) & (ctl.first_word ? ~ge_first : ALL);
      end
   end

   assign free_bits = ~word & mask;
   assign lowest    = free_bits & (~free_bits + WORD_BITS'(1));

   always_comb begin
      idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (lowest[i]) begin
            idx = idx | BIT_W'(i);
         end
      end
   end

   assign res.found   = |free_bits;
   assign res.bit_idx = idx;

endmodule
`default_nettype wire

// ----- src/sidalloc_ctrl.sv -----
`default_nettype none
module sidalloc_ctrl (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire sidalloc_pkg::req_type            req_data,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output sidalloc_pkg::rsp_type                 rsp_data,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire [sidalloc_pkg::LIMIT_W-1:0]       csr_data,
   output sidalloc_pkg::mem_ctrl_type            mem,
   input  wire [sidalloc_pkg::WORD_BITS-1:0]     bm_rd_data,
   input  wire [sidalloc_pkg::GEN_W-1:0]         gen_rd_data,
   output sidalloc_pkg::scan_ctrl_type           scan_ctl,
   input  wire sidalloc_pkg::scan_res_type       scan_res
);
   import sidalloc_pkg::*;

   typedef enum logic [7:0] {
      ST_CLEAR    = 8'b0000_0001,
      ST_IDLE     = 8'b0000_0010,
      ST_FREE_RD  = 8'b0000_0100,
      ST_FREE_WR  = 8'b0000_1000,
      ST_SCAN_RD  = 8'b0001_0000,
      ST_SCAN_CHK = 8'b0010_0000,
      ST_GEN_RD   = 8'b0100_0000,
      ST_DONE     = 8'b1000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [SLOT_W-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic [SLOT_W-1:0]    hint_ff, hint_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   rsp_type              res_ff, res_in;
   logic [LIMIT_W-1:0]   lim_ff, lim_in;
   logic [SLOT_W-1:0]    first_ff, first_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [WORD_AW-1:0]   word_ff, word_in;
   logic                 wrapped_ff, wrapped_in;
   logic [SLOT_W-1:0]    pos_ff, pos_in;

   logic [LIMIT_W-1:0]   eff_limit;
   logic                 accept;
   logic [SLOT_W-1:0]    lim_last;
   logic [WORD_AW-1:0]   first_word;
   logic [WORD_AW-1:0]   last_word;
   logic [SLOT_W-1:0]    found_pos;
   logic [LIMIT_W-1:0]   found_inc;
   logic                 rsp_free;

   always_comb begin
      if (limit_ff < LIMIT_W'(MIN_SLOTS)) begin
         eff_limit = LIMIT_W'(MIN_SLOTS);
      end else if (limit_ff > LIMIT_W'(MAX_SLOTS)) begin
         eff_limit = LIMIT_W'(MAX_SLOTS);
      end else begin
         eff_limit = limit_ff;
      end
   end

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign lim_last   = SLOT_W'(lim_ff - LIMIT_W'(1));
   assign first_word = first_ff[SLOT_W-1:BIT_W];
   assign last_word  = lim_last[SLOT_W-1:BIT_W];
   assign found_pos  = {word_ff, scan_res.bit_idx};
   assign found_inc  = {1'b0, found_pos} + LIMIT_W'(1);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign scan_ctl.wrapped    = wrapped_ff;
   assign scan_ctl.first_word = (word_ff == first_word);
   assign scan_ctl.last_word  = (word_ff == last_word);
   assign scan_ctl.word_zero  = (word_ff == '0);
   assign scan_ctl.first_bit  = first_ff[BIT_W-1:0];
   assign scan_ctl.last_bit   = lim_last[BIT_W-1:0];

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      limit_in     = limit_ff;
      hint_in      = hint_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      res_in       = res_ff;
      lim_in       = lim_ff;
      first_in     = first_ff;
      slot_in      = slot_ff;
      word_in      = word_ff;
      wrapped_in   = wrapped_ff;
      pos_in       = pos_ff;

      mem.bm_we     = 1'b0;
      mem.bm_addr   = word_ff;
      mem.bm_wdata  = bm_rd_data;
      mem.gen_we    = 1'b0;
      mem.gen_addr  = slot_ff;
      mem.gen_wdata = gen_rd_data + GEN_W'(1);

      if (csr_valid && csr_ready) begin
         limit_in = csr_data;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            // zero every generation, and the bitmap with slot 0 reserved
            mem.gen_we    = 1'b1;
            mem.gen_addr  = clr_cnt_ff;
            mem.gen_wdata = '0;
            mem.bm_we     = (clr_cnt_ff < SLOT_W'(BM_WORDS));
            mem.bm_addr   = clr_cnt_ff[WORD_AW-1:0];
            mem.bm_wdata  = (clr_cnt_ff == '0) ? WORD_BITS'(1) : '0;
            clr_cnt_in    = clr_cnt_ff + SLOT_W'(1);
            if (clr_cnt_ff == SLOT_W'(MAX_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               lim_in  = eff_limit;
               slot_in = req_data.slot_index;
               res_in  = '0;
               if (hint_ff == '0 || {1'b0, hint_ff} >= eff_limit) begin
                  first_in = SLOT_W'(1);
                  word_in  = '0;
               end else begin
                  first_in = hint_ff;
                  word_in  = hint_ff[SLOT_W-1:BIT_W];
               end
               wrapped_in = 1'b0;
               if (req_data.func == FUNC_FREE) begin
                  if (req_data.slot_index == '0
                      || {1'b0, req_data.slot_index} >= eff_limit) begin
                     res_in.status = STATUS_IGNORED;
                     state_in      = ST_DONE;
                  end else begin
                     state_in = ST_FREE_RD;
                  end
               end else begin
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_FREE_RD: begin
            mem.bm_addr = slot_ff[SLOT_W-1:BIT_W];
            state_in    = ST_FREE_WR;
         end
         ST_FREE_WR: begin
            mem.bm_addr  = slot_ff[SLOT_W-1:BIT_W];
            mem.bm_we    = 1'b1;
            mem.bm_wdata = bm_rd_data & ~(WORD_BITS'(1) << slot_ff[BIT_W-1:0]);
            mem.gen_we   = 1'b1;
            state_in     = ST_DONE;
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            mem.gen_addr = found_pos;
            if (scan_res.found) begin
               mem.bm_we    = 1'b1;
               mem.bm_wdata = bm_rd_data | (WORD_BITS'(1) << scan_res.bit_idx);
               pos_in       = found_pos;
               hint_in      = (found_inc < lim_ff) ? found_inc[SLOT_W-1:0] : SLOT_W'(1);
               state_in     = ST_GEN_RD;
            end else if (!wrapped_ff && word_ff == last_word) begin
               wrapped_in = 1'b1;
               word_in    = '0;
               state_in   = ST_SCAN_RD;
            end else if (wrapped_ff && word_ff == first_word) begin
               res_in.status = STATUS_NO_FREE;
               state_in      = ST_DONE;
            end else begin
               word_in  = word_ff + WORD_AW'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_GEN_RD: begin
            res_in.status             = STATUS_DONE;
            res_in.granted_index      = pos_ff;
            res_in.granted_generation = gen_rd_data;
            state_in                  = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         limit_ff     <= LIMIT_RESET;
         hint_ff      <= SLOT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         limit_ff     <= limit_in;
         hint_ff      <= hint_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      res_ff      <= res_in;
      lim_ff      <= lim_in;
      first_ff    <= first_in;
      slot_ff     <= slot_in;
      word_ff     <= word_in;
      wrapped_ff  <= wrapped_in;
      pos_ff      <= pos_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
